// ===== sv/lvb_pkg.sv =====
// ----------------------------------------------------------------------------
// lvb_pkg : shared constants and helpers for the look-at view basis
// Fixed inner precision, unit latency and the small arithmetic helpers used
// by the scaling stages.
// ----------------------------------------------------------------------------
package lvb_pkg;

    // fraction bits of the internal unit axes
    localparam int INNER_BITS = 30;
    // square root steps (two bits of radicand each) and quotient bits
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = INNER_BITS + 1;
    // squares, sum, root, divide, sign
    localparam int NORM_LAT   = 2 + SQRT_STEPS + DIV_STEPS + 1;

    typedef logic [63:0] mag_t;
    typedef logic [6:0]  len_t;

    function automatic mag_t mag64(input logic signed [63:0] x);
        mag_t r;
        r = x[63] ? mag_t'(-x) : mag_t'(x);
        return r;
    endfunction

    // number of bits up to and including the leading one
    function automatic len_t bit_len(input mag_t v);
        len_t n;
        n = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                n = len_t'(i + 1);
            end
        end
        return n;
    endfunction

    // align a magnitude so that a word of length len lands on INNER_BITS bits
    function automatic logic [INNER_BITS-1:0] scale_mag(input mag_t m, input len_t len);
        mag_t t;
        if (len > len_t'(INNER_BITS))
        begin
            t = m >> (len - len_t'(INNER_BITS));
        end
        else
        begin
            t = m << (len_t'(INNER_BITS) - len);
        end
        return t[INNER_BITS-1:0];
    endfunction

    function automatic logic signed [INNER_BITS:0] apply_sign(
        input logic [INNER_BITS-1:0] m, input logic neg);
        logic signed [INNER_BITS:0] s;
        s = $signed({1'b0, m});
        return neg ? -s : s;
    endfunction

endpackage

// ===== sv/lvb_norm.sv =====
// ----------------------------------------------------------------------------
// lvb_norm : pipelined vector normaliser
// Squares and sums a pre-scaled vector, takes the integer root one step per
// stage, then divides each component by the length one quotient bit per stage.
// ----------------------------------------------------------------------------
module lvb_norm (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [lvb_pkg::INNER_BITS:0]   vec  [3],
    output logic signed [lvb_pkg::INNER_BITS+1:0] axis [3]
);

    localparam int IB    = lvb_pkg::INNER_BITS;
    localparam int SQ_N  = lvb_pkg::SQRT_STEPS;
    localparam int DIV_N = lvb_pkg::DIV_STEPS;
    localparam int A_D   = SQ_N + 2;
    localparam int NEG_D = SQ_N + DIV_N + 2;

    logic [IB-1:0]     a_dly_reg   [A_D][3];
    logic              neg_dly_reg [NEG_D][3];
    logic [2*IB-1:0]   sq1_reg     [3];
    logic [2*IB+1:0]   sum2_reg;
    logic [63:0]       rt_s_reg    [SQ_N];
    logic [63:0]       rt_r_reg    [SQ_N];
    logic [63:0]       rt_s_next   [SQ_N];
    logic [63:0]       rt_r_next   [SQ_N];
    logic [2*IB+1:0]   dv_r_reg    [DIV_N][3];
    logic [IB:0]       dv_q_reg    [DIV_N][3];
    logic [31:0]       dv_len_reg  [DIV_N];
    logic [2*IB+1:0]   dv_r_next   [DIV_N][3];
    logic [IB:0]       dv_q_next   [DIV_N][3];
    logic [31:0]       dv_len_next [DIV_N];
    logic [IB-1:0]     am          [3];
    logic signed [IB+1:0] axis_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            am[i] = vec[i][IB] ? IB'(-vec[i]) : IB'(vec[i]);
        end
    end

    // root: one radicand bit pair per stage
    always_comb
    begin
        logic [63:0] s_in;
        logic [63:0] r_in;
        logic [63:0] bitv;
        logic [63:0] t;
        for (int k = 0; k < SQ_N; k++)
        begin
            s_in = (k == 0) ? 64'(sum2_reg) : rt_s_reg[(k == 0) ? 0 : k - 1];
            r_in = (k == 0) ? 64'd0 : rt_r_reg[(k == 0) ? 0 : k - 1];
            bitv = 64'd1 << (62 - 2 * k);
            t    = r_in + bitv;
            if (s_in >= t)
            begin
                rt_s_next[k] = s_in - t;
                rt_r_next[k] = (r_in >> 1) + bitv;
            end
            else
            begin
                rt_s_next[k] = s_in;
                rt_r_next[k] = r_in >> 1;
            end
        end
    end

    // restoring divide, rounded by adding half the divisor up front
    always_comb
    begin
        logic [2*IB+1:0] r_in;
        logic [IB:0]     q_in;
        logic [31:0]     l_in;
        logic [2*IB+1:0] t;
        for (int j = 0; j < DIV_N; j++)
        begin
            l_in = (j == 0) ? rt_r_reg[SQ_N-1][31:0] : dv_len_reg[(j == 0) ? 0 : j - 1];
            dv_len_next[j] = l_in;
            t = (2*IB+2)'(l_in) << (DIV_N - 1 - j);
            for (int i = 0; i < 3; i++)
            begin
                if (j == 0)
                begin
                    r_in = {2'b00, a_dly_reg[A_D-1][i], {IB{1'b0}}} + (2*IB+2)'(l_in >> 1);
                    q_in = '0;
                end
                else
                begin
                    r_in = dv_r_reg[(j == 0) ? 0 : j - 1][i];
                    q_in = dv_q_reg[(j == 0) ? 0 : j - 1][i];
                end
                if (r_in >= t)
                begin
                    dv_r_next[j][i] = r_in - t;
                    dv_q_next[j][i] = q_in | ((IB+1)'(1) << (DIV_N - 1 - j));
                end
                else
                begin
                    dv_r_next[j][i] = r_in;
                    dv_q_next[j][i] = q_in;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_dly_reg[0][i]   <= am[i];
                neg_dly_reg[0][i] <= vec[i][IB];
                sq1_reg[i]        <= (2*IB)'(am[i]) * (2*IB)'(am[i]);
                for (int k = 1; k < A_D; k++)
                begin
                    a_dly_reg[k][i] <= a_dly_reg[k-1][i];
                end
                for (int k = 1; k < NEG_D; k++)
                begin
                    neg_dly_reg[k][i] <= neg_dly_reg[k-1][i];
                end
                axis_reg[i] <= neg_dly_reg[NEG_D-1][i] ? -(IB+2)'(dv_q_reg[DIV_N-1][i])
                                                       : (IB+2)'(dv_q_reg[DIV_N-1][i]);
            end
            sum2_reg <= (2*IB+2)'(sq1_reg[0]) + (2*IB+2)'(sq1_reg[1])
                        + (2*IB+2)'(sq1_reg[2]);
            for (int k = 0; k < SQ_N; k++)
            begin
                rt_s_reg[k] <= rt_s_next[k];
                rt_r_reg[k] <= rt_r_next[k];
            end
            for (int j = 0; j < DIV_N; j++)
            begin
                dv_len_reg[j] <= dv_len_next[j];
                for (int i = 0; i < 3; i++)
                begin
                    dv_r_reg[j][i] <= dv_r_next[j][i];
                    dv_q_reg[j][i] <= dv_q_next[j][i];
                end
            end
        end
    end

    assign axis = axis_reg;

endmodule

// ===== sv/lookat_view_basis.sv =====
// ----------------------------------------------------------------------------
// lookat_view_basis : look-at camera basis and translations
// Eye, target and up in, side / true up / back axes and moves out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) takes one word of eye, target and up
//   vectors; output channel (out_valid / out_ready) gives one word of the
//   three unit axes and three translations per input word.
//   The pipeline holds 14 stages of scaling and cross products, 66 in the
//   normalisers (32 root steps and 31 quotient steps dominate) and 3 for the
//   dot products and output register.
//   Throughput is one word per cycle while out_ready is high.
//   All stages advance together; when the output word is held and out_ready
//   is low the whole pipeline freezes and in_ready drops, so nothing is lost
//   or repeated. Empty slots travel as bubbles.
//   Reset clears only the valid bits; the pipeline is empty afterwards.
//   A zero eye-minus-target or an up parallel to it gives an all-zero word.
// ----------------------------------------------------------------------------
module lookat_view_basis #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [31:0]                eye_x,
    input  logic signed [31:0]                eye_y,
    input  logic signed [31:0]                eye_z,
    input  logic signed [31:0]                target_x,
    input  logic signed [31:0]                target_y,
    input  logic signed [31:0]                target_z,
    input  logic signed [31:0]                up_x,
    input  logic signed [31:0]                up_y,
    input  logic signed [31:0]                up_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [FRACTION_BITS+1:0]   side_x,
    output logic signed [FRACTION_BITS+1:0]   side_y,
    output logic signed [FRACTION_BITS+1:0]   side_z,
    output logic signed [FRACTION_BITS+1:0]   true_up_x,
    output logic signed [FRACTION_BITS+1:0]   true_up_y,
    output logic signed [FRACTION_BITS+1:0]   true_up_z,
    output logic signed [FRACTION_BITS+1:0]   back_x,
    output logic signed [FRACTION_BITS+1:0]   back_y,
    output logic signed [FRACTION_BITS+1:0]   back_z,
    output logic signed [FRACTION_BITS+17:0]  move_x,
    output logic signed [FRACTION_BITS+17:0]  move_y,
    output logic signed [FRACTION_BITS+17:0]  move_z
);

    localparam int IB      = lvb_pkg::INNER_BITS;
    localparam int AW      = FRACTION_BITS + 2;
    localparam int MW      = FRACTION_BITS + 18;
    localparam int RS      = IB - FRACTION_BITS;
    localparam int NORM_IN = 14;
    localparam int AX_ST   = NORM_IN + lvb_pkg::NORM_LAT;
    localparam int LAT     = AX_ST + 3;
    localparam int NZ_D    = LAT - 4;
    localparam int DS_D    = NORM_IN - 4;
    localparam int CS_D    = NORM_IN - 9;

    logic en;
    logic v_reg [LAT];

    logic signed [31:0] eye_in [3];
    logic signed [31:0] tgt_in [3];
    logic signed [31:0] up_in  [3];

    // scaling of eye - target and up
    logic signed [32:0]   d1_reg   [3];
    logic signed [31:0]   up1_reg  [3];
    lvb_pkg::mag_t        dm2_reg  [3];
    lvb_pkg::mag_t        um2_reg  [3];
    logic                 dneg2_reg[3];
    logic                 uneg2_reg[3];
    lvb_pkg::mag_t        dor2_reg;
    lvb_pkg::mag_t        uor2_reg;
    lvb_pkg::mag_t        dm3_reg  [3];
    lvb_pkg::mag_t        um3_reg  [3];
    logic                 dneg3_reg[3];
    logic                 uneg3_reg[3];
    lvb_pkg::len_t        dlen3_reg;
    lvb_pkg::len_t        ulen3_reg;
    logic signed [IB:0]   ds4_reg  [3];
    logic signed [IB:0]   us4_reg  [3];
    // up x back, then its scaling
    logic signed [2*IB+1:0] pc5_reg [6];
    logic signed [2*IB+2:0] c6_reg  [3];
    lvb_pkg::mag_t        cm7_reg  [3];
    logic                 cneg7_reg[3];
    lvb_pkg::mag_t        cor7_reg;
    lvb_pkg::mag_t        cm8_reg  [3];
    logic                 cneg8_reg[3];
    lvb_pkg::len_t        clen8_reg;
    logic signed [IB:0]   cs9_reg  [3];
    // back x side, then its scaling
    logic signed [2*IB+1:0] pw10_reg [6];
    logic signed [2*IB+2:0] w11_reg  [3];
    lvb_pkg::mag_t        wm12_reg  [3];
    logic                 wneg12_reg[3];
    lvb_pkg::mag_t        wor12_reg;
    lvb_pkg::mag_t        wm13_reg  [3];
    logic                 wneg13_reg[3];
    lvb_pkg::len_t        wlen13_reg;
    logic signed [IB:0]   ws14_reg  [3];

    logic signed [IB:0]   ds_dly_reg [DS_D][3];
    logic signed [IB:0]   cs_dly_reg [CS_D][3];
    logic signed [31:0]   eye_dly_reg[AX_ST][3];
    logic                 nz_reg     [NZ_D];

    logic signed [IB+1:0] ax_side [3];
    logic signed [IB+1:0] ax_up   [3];
    logic signed [IB+1:0] ax_back [3];
    logic signed [IB+1:0] ax_all  [3][3];

    logic signed [63:0]   dp81_reg [3][3];
    logic [AW-1:0]        axr_next [3][3];
    logic [AW-1:0]        axr81_reg[3][3];
    logic [AW-1:0]        axr82_reg[3][3];
    logic signed [63:0]   dot82_reg[3];
    logic [MW-1:0]        mv_next  [3];
    logic [AW-1:0]        ax_out_reg[3][3];
    logic [MW-1:0]        mv_out_reg[3];

    lvb_pkg::mag_t        dor_next;
    lvb_pkg::mag_t        uor_next;
    lvb_pkg::mag_t        cor_next;
    lvb_pkg::mag_t        wor_next;

    assign en        = !v_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[LAT-1];

    assign eye_in = '{eye_x, eye_y, eye_z};
    assign tgt_in = '{target_x, target_y, target_z};
    assign up_in  = '{up_x, up_y, up_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_comb
    begin
        dor_next = '0;
        uor_next = '0;
        cor_next = '0;
        wor_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            dor_next = dor_next | lvb_pkg::mag64(64'(d1_reg[i]));
            uor_next = uor_next | lvb_pkg::mag64(64'(up1_reg[i]));
            cor_next = cor_next | lvb_pkg::mag64(64'(c6_reg[i]));
            wor_next = wor_next | lvb_pkg::mag64(64'(w11_reg[i]));
        end
    end

    // front end: scale, cross, scale, cross, scale
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i]  <= 33'(eye_in[i]) - 33'(tgt_in[i]);
                up1_reg[i] <= up_in[i];

                dm2_reg[i]   <= lvb_pkg::mag64(64'(d1_reg[i]));
                um2_reg[i]   <= lvb_pkg::mag64(64'(up1_reg[i]));
                dneg2_reg[i] <= d1_reg[i][32];
                uneg2_reg[i] <= up1_reg[i][31];

                dm3_reg[i]   <= dm2_reg[i];
                um3_reg[i]   <= um2_reg[i];
                dneg3_reg[i] <= dneg2_reg[i];
                uneg3_reg[i] <= uneg2_reg[i];

                ds4_reg[i] <= lvb_pkg::apply_sign(
                    lvb_pkg::scale_mag(dm3_reg[i], dlen3_reg), dneg3_reg[i]);
                us4_reg[i] <= lvb_pkg::apply_sign(
                    lvb_pkg::scale_mag(um3_reg[i], ulen3_reg), uneg3_reg[i]);

                cm7_reg[i]   <= lvb_pkg::mag64(64'(c6_reg[i]));
                cneg7_reg[i] <= c6_reg[i][2*IB+2];
                cm8_reg[i]   <= cm7_reg[i];
                cneg8_reg[i] <= cneg7_reg[i];
                cs9_reg[i]   <= lvb_pkg::apply_sign(
                    lvb_pkg::scale_mag(cm8_reg[i], clen8_reg), cneg8_reg[i]);

                wm12_reg[i]   <= lvb_pkg::mag64(64'(w11_reg[i]));
                wneg12_reg[i] <= w11_reg[i][2*IB+2];
                wm13_reg[i]   <= wm12_reg[i];
                wneg13_reg[i] <= wneg12_reg[i];
                ws14_reg[i]   <= lvb_pkg::apply_sign(
                    lvb_pkg::scale_mag(wm13_reg[i], wlen13_reg), wneg13_reg[i]);

                ds_dly_reg[0][i] <= ds4_reg[i];
                for (int k = 1; k < DS_D; k++)
                begin
                    ds_dly_reg[k][i] <= ds_dly_reg[k-1][i];
                end
                cs_dly_reg[0][i] <= cs9_reg[i];
                for (int k = 1; k < CS_D; k++)
                begin
                    cs_dly_reg[k][i] <= cs_dly_reg[k-1][i];
                end
                eye_dly_reg[0][i] <= eye_in[i];
                for (int k = 1; k < AX_ST; k++)
                begin
                    eye_dly_reg[k][i] <= eye_dly_reg[k-1][i];
                end
            end

            dor2_reg  <= dor_next;
            uor2_reg  <= uor_next;
            dlen3_reg <= lvb_pkg::bit_len(dor2_reg);
            ulen3_reg <= lvb_pkg::bit_len(uor2_reg);
            cor7_reg  <= cor_next;
            clen8_reg <= lvb_pkg::bit_len(cor7_reg);
            wor12_reg <= wor_next;
            wlen13_reg <= lvb_pkg::bit_len(wor12_reg);

            // c = us x ds
            pc5_reg[0] <= (2*IB+2)'(us4_reg[1]) * (2*IB+2)'(ds4_reg[2]);
            pc5_reg[1] <= (2*IB+2)'(us4_reg[2]) * (2*IB+2)'(ds4_reg[1]);
            pc5_reg[2] <= (2*IB+2)'(us4_reg[2]) * (2*IB+2)'(ds4_reg[0]);
            pc5_reg[3] <= (2*IB+2)'(us4_reg[0]) * (2*IB+2)'(ds4_reg[2]);
            pc5_reg[4] <= (2*IB+2)'(us4_reg[0]) * (2*IB+2)'(ds4_reg[1]);
            pc5_reg[5] <= (2*IB+2)'(us4_reg[1]) * (2*IB+2)'(ds4_reg[0]);
            for (int i = 0; i < 3; i++)
            begin
                c6_reg[i]  <= (2*IB+3)'(pc5_reg[2*i]) - (2*IB+3)'(pc5_reg[2*i+1]);
                w11_reg[i] <= (2*IB+3)'(pw10_reg[2*i]) - (2*IB+3)'(pw10_reg[2*i+1]);
            end

            // w = ds x cs, ds taken from its stage-9 slot
            pw10_reg[0] <= (2*IB+2)'(ds_dly_reg[4][1]) * (2*IB+2)'(cs9_reg[2]);
            pw10_reg[1] <= (2*IB+2)'(ds_dly_reg[4][2]) * (2*IB+2)'(cs9_reg[1]);
            pw10_reg[2] <= (2*IB+2)'(ds_dly_reg[4][2]) * (2*IB+2)'(cs9_reg[0]);
            pw10_reg[3] <= (2*IB+2)'(ds_dly_reg[4][0]) * (2*IB+2)'(cs9_reg[2]);
            pw10_reg[4] <= (2*IB+2)'(ds_dly_reg[4][0]) * (2*IB+2)'(cs9_reg[1]);
            pw10_reg[5] <= (2*IB+2)'(ds_dly_reg[4][1]) * (2*IB+2)'(cs9_reg[0]);

            // direction flag: back, side and true up all nonzero
            nz_reg[0] <= dlen3_reg != '0;
            for (int k = 1; k < NZ_D; k++)
            begin
                if (k == 5)
                begin
                    nz_reg[k] <= nz_reg[k-1] && (clen8_reg != '0);
                end
                else if (k == 10)
                begin
                    nz_reg[k] <= nz_reg[k-1] && (wlen13_reg != '0);
                end
                else
                begin
                    nz_reg[k] <= nz_reg[k-1];
                end
            end
        end
    end

    lvb_norm u_norm_back (
        .clk  (clk),
        .en   (en),
        .vec  (ds_dly_reg[DS_D-1]),
        .axis (ax_back)
    );

    lvb_norm u_norm_side (
        .clk  (clk),
        .en   (en),
        .vec  (cs_dly_reg[CS_D-1]),
        .axis (ax_side)
    );

    lvb_norm u_norm_up (
        .clk  (clk),
        .en   (en),
        .vec  (ws14_reg),
        .axis (ax_up)
    );

    assign ax_all[0] = ax_side;
    assign ax_all[1] = ax_up;
    assign ax_all[2] = ax_back;

    // axis rounding to output precision, half away from zero
    always_comb
    begin
        logic [31:0] am;
        logic [31:0] ar;
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                am = ax_all[k][i][IB+1] ? 32'(-ax_all[k][i]) : 32'(ax_all[k][i]);
                ar = (am + (32'd1 << (RS - 1))) >> RS;
                axr_next[k][i] = ax_all[k][i][IB+1] ? AW'(-ar) : AW'(ar);
            end
        end
    end

    // move = -round(axis . eye), saturated
    always_comb
    begin
        logic [63:0] dm;
        logic [63:0] m2;
        logic [63:0] lim;
        logic [63:0] mv;
        lim = 64'd1 << (MW - 1);
        for (int k = 0; k < 3; k++)
        begin
            dm = lvb_pkg::mag64(dot82_reg[k]);
            m2 = (dm + (64'd1 << (IB - 1))) >> IB;
            if (dot82_reg[k][63])
            begin
                mv = (m2 > lim - 64'd1) ? lim - 64'd1 : m2;
            end
            else
            begin
                mv = (m2 > lim) ? -lim : -m2;
            end
            mv_next[k] = MW'(mv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dp81_reg[k][i]  <= 64'(ax_all[k][i]) * 64'(eye_dly_reg[AX_ST-1][i]);
                    axr81_reg[k][i] <= axr_next[k][i];
                    axr82_reg[k][i] <= axr81_reg[k][i];
                    ax_out_reg[k][i] <= nz_reg[NZ_D-1] ? axr82_reg[k][i] : '0;
                end
                dot82_reg[k]  <= dp81_reg[k][0] + dp81_reg[k][1] + dp81_reg[k][2];
                mv_out_reg[k] <= nz_reg[NZ_D-1] ? mv_next[k] : '0;
            end
        end
    end

    assign side_x    = ax_out_reg[0][0];
    assign side_y    = ax_out_reg[0][1];
    assign side_z    = ax_out_reg[0][2];
    assign true_up_x = ax_out_reg[1][0];
    assign true_up_y = ax_out_reg[1][1];
    assign true_up_z = ax_out_reg[1][2];
    assign back_x    = ax_out_reg[2][0];
    assign back_y    = ax_out_reg[2][1];
    assign back_z    = ax_out_reg[2][2];
    assign move_x    = mv_out_reg[0];
    assign move_y    = mv_out_reg[1];
    assign move_z    = mv_out_reg[2];

endmodule
